[rtl/core/qsb_pkg.sv]
// Shared types, constants and helpers for the quaternion slerp blend core.
package qsb_pkg;

  // CORDIC arctangent table, atan(2^-i) in radians, Q.28, rounded
  localparam int ATAN_N = 32;
  localparam logic signed [31:0] ATAN_TAB [ATAN_N] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2,
    32'sd1,         32'sd1,         32'sd0,        32'sd0
  };

  // square root pipeline: one result bit per stage, 29 result bits
  localparam int ISQ_STEPS = 29;
  // divider: 17 quotient bits, then a saturation stage
  localparam int DIV_LAT = 18;
  // queue between front and back; depth is a power of two
  localparam int QDEPTH = 4;
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  localparam logic [14:0] ONE_Q14 = 15'd16384;

  // path codes
  localparam logic [1:0] PATH_COPY   = 2'd0;
  localparam logic [1:0] PATH_LINEAR = 2'd1;
  localparam logic [1:0] PATH_SLERP  = 2'd2;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    logic        [14:0] blend_weight;
  } slerp_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
    logic        [1:0]  path_taken;
  } slerp_out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic             copy;   // dot at or beyond one
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;      // already negated when dot was negative
    logic [14:0]      t;      // clamped weight
    logic [28:0]      dot;    // magnitude of dot, valid when not copy
  } qsb_item_t;

  // side data riding along the back pipeline
  typedef struct packed {
    qsb_item_t        item;
    logic             lin_s;
    logic             linear;
    logic [3:0][15:0] linres;
  } qsb_side_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/quaternion_slerp_blend_core.sv]
// Top level of the quaternion slerp blend core.
//
// Usage: drive a word of two quaternions and a weight on item and raise
// start; the word is taken at a clock edge where start is high and busy is
// low. busy only rises if the internal queue could overflow, so in normal
// streaming one word is taken every cycle.
// Each result appears on result for exactly one cycle with done high,
// once its word has passed the front, the queue and the back pipeline.
// Results leave in the order the words came in.
// Throughput is one word per cycle: the square root, the CORDIC units and
// the four dividers are fully pipelined, one bit or one micro-rotation per
// stage, and the front-to-back queue is drained every cycle.
// The receiver cannot stall: done is not held and no result waits.
// wr_en/wr_data write the small-sine limit; write it only while idle.
// Reset (rst, synchronous) empties the pipeline and sets the limit to 1.
module quaternion_slerp_blend_core import qsb_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  slerp_in_t   item,
  output logic        busy,
  input  logic        wr_en,
  input  logic [14:0] wr_data,
  output logic        done,
  output slerp_out_t  result
);

  logic [14:0]       small_sine_limit;
  logic              push;
  qsb_item_t         push_item;
  logic [QLVL_W-1:0] level;
  logic              q_valid;
  qsb_item_t         q_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      small_sine_limit <= 15'd1;
    end else if (wr_en) begin
      small_sine_limit <= wr_data;
    end
  end

  qsb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .level     (level),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  qsb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .level     (level),
    .out_valid (q_valid),
    .out_item  (q_item)
  );

  qsb_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_item  (q_item),
    .limit    (small_sine_limit),
    .done     (done),
    .result   (result)
  );

endmodule

[rtl/core/qsb_front.sv]
// Front: accepts words, forms the dot product, folds the sign and classifies.
module qsb_front import qsb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  slerp_in_t         item,
  input  logic [QLVL_W-1:0] level,
  output logic              busy,
  output logic              push,
  output qsb_item_t         push_item
);

  logic                    accept;
  logic                    v1;
  logic signed [31:0]      p [4];
  logic [3:0][15:0]        ain;
  logic [3:0][15:0]        bin;
  logic [3:0][15:0]        a1;
  logic [3:0][15:0]        b1;
  logic [14:0]             t1;
  logic signed [33:0]      dot;
  logic [33:0]             absd;
  logic                    neg;

  assign ain = {item.a_x, item.a_y, item.a_z, item.a_w};
  assign bin = {item.b_x, item.b_y, item.b_z, item.b_w};

  // hold off when the queue plus the word in flight could fill it
  assign busy   = (4'(level) + 4'(v1)) >= 4'(QDEPTH);
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  // stage 1: products, operands and clamped weight
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < 4; j++) begin
        p[j] <= $signed(ain[j]) * $signed(bin[j]);
      end
      a1 <= ain;
      b1 <= bin;
      t1 <= (item.blend_weight > ONE_Q14) ? ONE_Q14 : item.blend_weight;
    end
  end

  // stage 2: sum, sign fold, classify
  assign dot  = 34'(p[0]) + 34'(p[1]) + 34'(p[2]) + 34'(p[3]);
  assign neg  = dot[33];
  assign absd = neg ? 34'(-dot) : 34'(dot);

  always_comb begin
    push_item.copy = absd[33:28] != 6'd0;
    push_item.a    = a1;
    push_item.t    = t1;
    push_item.dot  = absd[28:0];
    for (int j = 0; j < 4; j++) begin
      push_item.b[j] = neg ? 17'(-17'($signed(b1[j]))) : 17'($signed(b1[j]));
    end
  end

  assign push = v1;

endmodule

[rtl/core/qsb_queue.sv]
// Short queue of classified words between front and back.
module qsb_queue import qsb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qsb_item_t         push_item,
  output logic [QLVL_W-1:0] level,
  output logic              out_valid,
  output qsb_item_t         out_item
);

  localparam int PW = $clog2(QDEPTH);

  qsb_item_t   mem [QDEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic          pop;

  // back takes a word every cycle one is present
  assign pop       = level != '0;
  assign out_valid = pop;
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

endmodule

[rtl/core/qsb_cordic.sv]
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
module qsb_cordic import qsb_pkg::*; #(
  parameter int STEPS     = 16,
  parameter bit VECTORING = 1'b0
) (
  input  logic               clk,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic signed [31:0] z_in,
  output logic signed [31:0] y_out,
  output logic signed [31:0] z_out
);

  logic signed [31:0] x [STEPS];
  logic signed [31:0] y [STEPS+1];
  logic signed [31:0] z [STEPS+1];

  assign x[0]  = x_in;
  assign y[0]  = y_in;
  assign z[0]  = z_in;
  assign y_out = y[STEPS];
  assign z_out = z[STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic plus;
    // vectoring drives y toward zero, rotation drives z toward zero
    assign plus = VECTORING ? ~y[i][31] : z[i][31];

    always_ff @(posedge clk) begin
      if (plus) begin
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATAN_TAB[i];
      end else begin
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATAN_TAB[i];
      end
    end

    if (i < STEPS - 1) begin : g_x
      always_ff @(posedge clk) begin
        if (plus) begin
          x[i+1] <= x[i] + (y[i] >>> i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
        end
      end
    end
  end

endmodule

[rtl/core/qsb_div.sv]
// Pipelined restoring divider with rounding already folded in, saturated to 16 bits.
module qsb_div import qsb_pkg::*; (
  input  logic               clk,
  input  logic [45:0]        mag,
  input  logic [29:0]        den,
  input  logic               neg,
  output logic signed [15:0] q_out
);

  localparam int QB = DIV_LAT - 1;

  logic [45:0]   r [QB+1];
  logic [QB-1:0] q [QB+1];
  logic [29:0]   d [QB+1];
  logic          n [QB+1];
  logic          o [QB+1];
  logic [QB-1:0] qm;

  assign r[0] = mag;
  assign q[0] = '0;
  assign d[0] = den;
  assign n[0] = neg;
  // quotient too wide for the result: saturate
  assign o[0] = 47'(mag) >= {den, QB'(0)};

  for (genvar j = 0; j < QB; j++) begin : g_bit
    localparam int K = QB - 1 - j;
    logic [45:0] dk;
    assign dk = 46'(d[j]) << K;

    always_ff @(posedge clk) begin
      d[j+1] <= d[j];
      n[j+1] <= n[j];
      o[j+1] <= o[j];
      if (r[j] >= dk) begin
        r[j+1] <= r[j] - dk;
        q[j+1] <= q[j] | (QB'(1) << K);
      end else begin
        r[j+1] <= r[j];
        q[j+1] <= q[j];
      end
    end
  end

  assign qm = o[QB] ? '1 : q[QB];

  // sign and saturate
  always_ff @(posedge clk) begin
    q_out <= sat16(n[QB] ? $signed(-36'(qm)) : $signed(36'(qm)));
  end

endmodule

[rtl/core/qsb_back.sv]
// Back: square root, angle, sines, blends and division, one word per cycle.
module qsb_back import qsb_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  qsb_item_t  in_item,
  input  logic [14:0] limit,
  output logic       done,
  output slerp_out_t result
);

  // stage indexes along the side line
  localparam int V0 = 1 + ISQ_STEPS;          // root ready
  localparam int T0 = V0 + CORDIC_STEPS;      // half angle ready
  localparam int R0 = T0 + 2 + CORDIC_STEPS;  // sines ready
  localparam int E  = R0 + 2 + DIV_LAT;       // quotients ready

  qsb_side_t side [E+1];
  qsb_side_t side_d [E];
  logic [E:0] vld;

  logic                     lin_s_c;
  logic                     linear_c;
  logic [3:0][15:0]         linres_c;

  logic [57:0]              sq;
  logic [57:0]              rem  [ISQ_STEPS+1];
  logic [28:0]              root [ISQ_STEPS+1];

  logic signed [31:0]       theta;
  logic signed [47:0]       prod;
  logic signed [31:0]       th1;
  logic signed [47:0]       angb_full;
  logic signed [31:0]       anga;
  logic signed [31:0]       angb;
  logic signed [31:0]       th2;
  logic signed [31:0]       sin_d;
  logic signed [31:0]       sin_a;
  logic signed [31:0]       sin_b;

  logic signed [49:0]       pa [4];
  logic signed [49:0]       pb [4];
  logic signed [33:0]       la [4];
  logic signed [33:0]       lb [4];
  logic signed [31:0]       sd1;
  logic [45:0]              mag [4];
  logic                     mneg [4];
  logic [29:0]              den;
  logic signed [15:0]       quo [4];

  assign side[0] = '{item: in_item, lin_s: 1'b0, linear: 1'b0, linres: '0};
  assign vld[0]  = in_valid;

  // values merged into the side line where they are produced
  always_comb begin
    for (int k = 0; k < E; k++) begin
      side_d[k] = side[k];
    end
    side_d[V0].lin_s  = lin_s_c;
    side_d[R0].linear = linear_c;
    side_d[R0+1].linres = linres_c;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < E; k++) begin
      side[k+1] <= side_d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[E:1] <= '0;
    end else begin
      vld[E:1] <= vld[E-1:0];
    end
  end

  // square of dot, then 1 - dot^2 into the root pipeline
  always_ff @(posedge clk) begin
    sq <= in_item.dot * in_item.dot;
  end

  assign rem[0]  = (58'(1) << 56) - sq;
  assign root[0] = '0;

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
    localparam int K = ISQ_STEPS - 1 - j;
    logic [57:0] test;
    assign test = (58'(root[j]) << (K + 1)) + (58'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rem[j] >= test) begin
        rem[j+1]  <= rem[j] - test;
        root[j+1] <= root[j] | (29'(1) << K);
      end else begin
        rem[j+1]  <= rem[j];
        root[j+1] <= root[j];
      end
    end
  end

  assign lin_s_c = root[ISQ_STEPS] < {limit, 14'd0};

  // half angle from (dot, sine)
  qsb_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b1)) u_vec (
    .clk   (clk),
    .x_in  ($signed({3'b000, side[V0].item.dot})),
    .y_in  ($signed({3'b000, root[ISQ_STEPS]})),
    .z_in  (32'sd0),
    .y_out (),
    .z_out (theta)
  );

  // split the angle by the weight
  assign angb_full = (prod + 48'sd8192) >>> 14;

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, side[T0].item.t}) * theta;
    th1  <= theta;
    angb <= angb_full[31:0];
    anga <= th1 - angb_full[31:0];
    th2  <= th1;
  end

  qsb_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_sin_d (
    .clk (clk), .x_in (32'sd268435456), .y_in (32'sd0), .z_in (th2),
    .y_out (sin_d), .z_out ()
  );

  qsb_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_sin_a (
    .clk (clk), .x_in (32'sd268435456), .y_in (32'sd0), .z_in (anga),
    .y_out (sin_a), .z_out ()
  );

  qsb_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_sin_b (
    .clk (clk), .x_in (32'sd268435456), .y_in (32'sd0), .z_in (angb),
    .y_out (sin_b), .z_out ()
  );

  // products for both blends
  assign linear_c = side[R0].lin_s | (sin_d <= 32'sd0);

  always_ff @(posedge clk) begin
    sd1 <= sin_d;
    for (int j = 0; j < 4; j++) begin
      pa[j] <= $signed(side[R0].item.a[j]) * sin_a;
      pb[j] <= $signed(side[R0].item.b[j]) * sin_b;
      la[j] <= $signed(side[R0].item.a[j]) * $signed({1'b0, ONE_Q14 - side[R0].item.t});
      lb[j] <= $signed(side[R0].item.b[j]) * $signed({1'b0, side[R0].item.t});
    end
  end

  // linear result, and numerator magnitude with half the divisor for rounding
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      linres_c[j] = sat16(36'((la[j] + lb[j] + 34'sd8192) >>> 14));
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_num
    logic signed [49:0] num;
    logic [49:0]        absn;
    assign num  = pa[j] + pb[j];
    assign absn = num[49] ? 50'(-num) : 50'(num);

    always_ff @(posedge clk) begin
      mneg[j] <= num[49];
      mag[j]  <= absn[45:0] + 46'(sd1[29:1]);
    end

    qsb_div u_div (
      .clk   (clk),
      .mag   (mag[j]),
      .den   (den),
      .neg   (mneg[j]),
      .q_out (quo[j])
    );
  end

  always_ff @(posedge clk) begin
    den <= sd1[29:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[E];
    end
  end

  always_ff @(posedge clk) begin
    if (side[E].item.copy) begin
      result.out_x      <= $signed(side[E].item.a[3]);
      result.out_y      <= $signed(side[E].item.a[2]);
      result.out_z      <= $signed(side[E].item.a[1]);
      result.out_w      <= $signed(side[E].item.a[0]);
      result.path_taken <= PATH_COPY;
    end else if (side[E].linear) begin
      result.out_x      <= $signed(side[E].linres[3]);
      result.out_y      <= $signed(side[E].linres[2]);
      result.out_z      <= $signed(side[E].linres[1]);
      result.out_w      <= $signed(side[E].linres[0]);
      result.path_taken <= PATH_LINEAR;
    end else begin
      result.out_x      <= quo[3];
      result.out_y      <= quo[2];
      result.out_z      <= quo[1];
      result.out_w      <= quo[0];
      result.path_taken <= PATH_SLERP;
    end
  end

endmodule

[test/quaternion_slerp_blend_core_test.sv]
// Testbench for the quaternion slerp blend core: directed table, then random words.
module quaternion_slerp_blend_core_test;
  import qsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 54;
  localparam int N_RANDOM = 900;
  localparam int N_DIRECTED = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  slerp_in_t item = '0;
  logic busy;
  logic wr_en = 1'b0;
  logic [14:0] wr_data = '0;
  logic done;
  slerp_out_t result;

  quaternion_slerp_blend_core #(.CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .wr_en(wr_en), .wr_data(wr_data), .done(done), .result(result)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [14:0] sine_limit = 15'd1;
  slerp_out_t blend_queue[$];
  int mismatches = 0;
  logic idle_ok = 1'b1;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint atan_q28(int i);
    longint acc, term, e;
    longint k;
    if (i == 0) return 64'sd210828714;
    acc = 0;
    k = 0;
    forever begin
      e = 60 - i * (2 * k + 1);
      if (e < 0) break;
      term = longint'((64'd1 << e) / longint'(2 * k + 1));
      acc += (k % 2 == 1) ? -term : term;
      k++;
    end
    return (acc + (64'sd1 << 31)) >>> 32;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q28(i);
      end else begin
        x -= dx; y += dy; z -= atan_q28(i);
      end
    end
    return z;
  endfunction

  function automatic longint rotate_sine(longint z);
    longint x, y, dx, dy;
    x = 64'sd1 << 28;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q28(i);
      end else begin
        x += dx; y -= dy; z += atan_q28(i);
      end
    end
    return y;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic slerp_out_t predict_blend(slerp_in_t w, logic [14:0] lim);
    longint a[4], b[4], dot, t, s, theta, ang_a, ang_b, sin_d, sin_a, sin_b, num;
    logic signed [15:0] o[4];
    slerp_out_t r;
    a[0] = longint'(w.a_x); a[1] = longint'(w.a_y);
    a[2] = longint'(w.a_z); a[3] = longint'(w.a_w);
    b[0] = longint'(w.b_x); b[1] = longint'(w.b_y);
    b[2] = longint'(w.b_z); b[3] = longint'(w.b_w);
    dot = 0;
    for (int j = 0; j < 4; j++) dot += a[j] * b[j];
    t = longint'(w.blend_weight);
    if (t > 16384) t = 16384;
    if (dot < 0) begin
      for (int j = 0; j < 4; j++) b[j] = -b[j];
      dot = -dot;
    end
    if (dot >= (64'sd1 << 28)) begin
      for (int j = 0; j < 4; j++) o[j] = clip16(a[j]);
      r.path_taken = PATH_COPY;
    end else begin
      s = int_sqrt((64'd1 << 56) - longint'(dot) * longint'(dot));
      theta = vector_angle(dot, s);
      ang_b = (t * theta + 8192) >>> 14;
      ang_a = theta - ang_b;
      sin_d = rotate_sine(theta);
      if (s < (longint'(lim) << 14) || sin_d <= 0) begin
        for (int j = 0; j < 4; j++)
          o[j] = clip16((a[j] * (16384 - t) + b[j] * t + 8192) >>> 14);
        r.path_taken = PATH_LINEAR;
      end else begin
        sin_a = rotate_sine(ang_a);
        sin_b = rotate_sine(ang_b);
        for (int j = 0; j < 4; j++) begin
          num = a[j] * sin_a + b[j] * sin_b;
          o[j] = clip16(round_div(num, sin_d));
        end
        r.path_taken = PATH_SLERP;
      end
    end
    r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2]; r.out_w = o[3];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    slerp_out_t exp_w;
    if (!rst && done) begin
      if (blend_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", result);
      end else begin
        exp_w = blend_queue.pop_front();
        if (result !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d w=%0d p=%0d got x=%0d y=%0d z=%0d w=%0d p=%0d",
                     exp_w.out_x, exp_w.out_y, exp_w.out_z, exp_w.out_w, exp_w.path_taken,
                     result.out_x, result.out_y, result.out_z, result.out_w,
                     result.path_taken);
        end
      end
    end
  end

  // directed stimulus table
  slerp_in_t dir_tab[N_DIRECTED];
  logic dir_has[N_DIRECTED];
  slerp_out_t dir_exp[N_DIRECTED];

  function automatic slerp_in_t mk(int ax, int ay, int az, int aw,
                                   int bx, int by, int bz, int bw, int t);
    slerp_in_t w;
    w.a_x = 16'(ax); w.a_y = 16'(ay); w.a_z = 16'(az); w.a_w = 16'(aw);
    w.b_x = 16'(bx); w.b_y = 16'(by); w.b_z = 16'(bz); w.b_w = 16'(bw);
    w.blend_weight = 15'(t);
    return w;
  endfunction

  function automatic slerp_out_t mo(int x, int y, int z, int w, logic [1:0] p);
    slerp_out_t r;
    r.out_x = 16'(x); r.out_y = 16'(y); r.out_z = 16'(z); r.out_w = 16'(w);
    r.path_taken = p;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < N_DIRECTED; i++) dir_has[i] = 1'b0;
    // identical unit quaternions: copy
    dir_tab[0] = mk(0, 0, 0, 16384, 0, 0, 0, 16384, 8192);
    dir_has[0] = 1'b1; dir_exp[0] = mo(0, 0, 0, 16384, PATH_COPY);
    // opposite quaternions: negation gives dot one, copy
    dir_tab[1] = mk(0, 0, 0, 16384, 0, 0, 0, -16384, 4096);
    dir_has[1] = 1'b1; dir_exp[1] = mo(0, 0, 0, 16384, PATH_COPY);
    // extremes, dot far beyond one: copy
    dir_tab[2] = mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    dir_has[2] = 1'b1; dir_exp[2] = mo(-32768, -32768, -32768, -32768, PATH_COPY);
    dir_tab[3] = mk(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767);
    dir_has[3] = 1'b1; dir_exp[3] = mo(32767, 32767, 32767, 32767, PATH_COPY);
    // orthogonal, weight 0, half, one, above one
    dir_tab[4] = mk(16384, 0, 0, 0, 0, 16384, 0, 0, 0);
    dir_tab[5] = mk(16384, 0, 0, 0, 0, 16384, 0, 0, 8192);
    dir_tab[6] = mk(16384, 0, 0, 0, 0, 16384, 0, 0, 16384);
    dir_tab[7] = mk(16384, 0, 0, 0, 0, 16384, 0, 0, 32767);
    // all zero: dot zero, sine one
    dir_tab[8] = mk(0, 0, 0, 0, 0, 0, 0, 0, 5000);
    // negative dot with -32768 in B
    dir_tab[9] = mk(8000, 0, 0, 0, -32768, 100, 0, 0, 3000);
    // close angles: small sine; then assorted further words
    dir_tab[10] = mk(0, 0, 0, 16384, 0, 0, 30, 16383, 9000);
    dir_tab[11] = mk(0, 0, 0, 16384, 0, 0, 1, 16383, 12000);
    dir_tab[12] = mk(11585, 0, 0, 11585, 0, 11585, 0, 11585, 16383);
    dir_tab[13] = mk(-32768, 32767, 0, 0, 0, 0, 32767, -32768, 1);
    dir_tab[14] = mk(100, -200, 300, -400, -500, 600, -700, 800, 16385);
    dir_tab[15] = mk(16000, 1000, -2000, 0, 15000, -3000, 2000, 4000, 7000);
  end

  // start stays high between back-to-back words, drops only while idling
  task automatic send_word(slerp_in_t w, logic has_exp, slerp_out_t given);
    slerp_out_t p;
    while (idle_ok && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(negedge clk);
    end
    p = predict_blend(w, sine_limit);
    if (has_exp && p !== given) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees with predictor for %h", w);
    end
    item <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    blend_queue.push_back(has_exp ? given : p);
    @(negedge clk);
  endtask

  task automatic drain_and_write(logic [14:0] v);
    start <= 1'b0;
    while (blend_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    wr_en <= 1'b1;
    wr_data <= v;
    sine_limit = v;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic signed [15:0] r16();
    return 16'($urandom);
  endfunction

  function automatic slerp_in_t rand_word();
    slerp_in_t w;
    int mode, sc, dz;
    mode = $urandom_range(9);
    if (mode < 2) begin
      // raw noise over the whole field range
      w = {r16(), r16(), r16(), r16(), r16(), r16(), r16(), r16(), 15'($urandom)};
    end else begin
      // components within half of one, B a small or large perturbation of A, maybe negated
      sc = 8192;
      w.a_x = 16'($urandom_range(2 * sc) - sc); w.a_y = 16'($urandom_range(2 * sc) - sc);
      w.a_z = 16'($urandom_range(2 * sc) - sc); w.a_w = 16'($urandom_range(2 * sc) - sc);
      dz = (mode < 6) ? (1 << $urandom_range(12)) : 16384;
      w.b_x = 16'(w.a_x + $urandom_range(2 * dz) - dz);
      w.b_y = 16'(w.a_y + $urandom_range(2 * dz) - dz);
      w.b_z = 16'(w.a_z + $urandom_range(2 * dz) - dz);
      w.b_w = 16'(w.a_w + $urandom_range(2 * dz) - dz);
      if ($urandom_range(1)) begin
        w.b_x = -w.b_x; w.b_y = -w.b_y; w.b_z = -w.b_z; w.b_w = -w.b_w;
      end
      w.blend_weight = ($urandom_range(9) == 0) ? 15'($urandom)
                                                : 15'($urandom_range(16384));
    end
    return w;
  endfunction

  initial begin
    logic [14:0] limits[6];
    limits = '{15'd0, 15'd16384, 15'd200, 15'd32767, 15'd4000, 15'd1};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed table at the reset limit
    for (int i = 0; i < N_DIRECTED; i++)
      send_word(dir_tab[i], dir_has[i], dir_exp[i]);
    // random phases over several limits
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write(limits[ph]);
      idle_ok = (ph != 2);
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        send_word(rand_word(), 1'b0, '0);
        // one hold-off until the pipeline is empty
        if (ph == 4 && k == 50) begin
          start <= 1'b0;
          while (blend_queue.size() != 0) @(negedge clk);
        end
      end
      for (int i = 4; i < N_DIRECTED && ph == 3; i++)
        send_word(dir_tab[i], 1'b0, '0);
    end
    start <= 1'b0;
    while (blend_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[quaternion_slerp_blend_core.f]
rtl/core/qsb_pkg.sv
rtl/core/qsb_front.sv
rtl/core/qsb_queue.sv
rtl/core/qsb_cordic.sv
rtl/core/qsb_div.sv
rtl/core/qsb_back.sv
rtl/core/quaternion_slerp_blend_core.sv
test/quaternion_slerp_blend_core_test.sv
